// ===== rtl/core/addressable_led_bit_slicer_macros.svh =====
// ----------------------------------------------------------------------------
// Addressable LED bit slicer assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_BIT_SLICER_MACROS_SVH
`define ADDRESSABLE_LED_BIT_SLICER_MACROS_SVH

// condition must hold at every edge out of reset
`define ALBS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("albs assertion failed");

// consequence must hold in the cycle after the antecedent
`define ALBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("albs assertion failed");

`endif

// ===== rtl/core/albs_pkg.sv =====
// ----------------------------------------------------------------------------
// Addressable LED bit slicer package
// Widths, sizing constants, slot descriptor type and slice pattern helper.
// ----------------------------------------------------------------------------
package albs_pkg;

  // serializer geometry
  localparam int unsigned BITS_PER_SLOT  = 24;
  localparam int unsigned SLICES_PER_BIT = 4;

  // field widths
  localparam int unsigned ColorW   = 24;
  localparam int unsigned PatW     = 4;
  localparam int unsigned SlotW    = 11;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned LedW     = 10;
  localparam int unsigned LatchW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned BitCntW  = $clog2(BITS_PER_SLOT);

  // register indexes and reset values
  localparam logic [CfgIdxW-1:0] RegLedCount   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLatchSlots = 1'd1;
  localparam logic [LedW-1:0]    LedCountRst   = 10'd64;
  localparam logic [LatchW-1:0]  LatchSlotsRst = 4'd4;

  // slice patterns
  localparam logic [PatW-1:0] PatOne4  = 4'hE;
  localparam logic [PatW-1:0] PatOne3  = 4'hC;
  localparam logic [PatW-1:0] PatZero  = 4'h8;
  localparam logic [PatW-1:0] PatIdle  = 4'h0;

  // front to back queue depth
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // one classified slot
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [SlotW-1:0]  slot_index;
    logic              in_latch;
    logic [FrameW-1:0] frame_number;
  } slot_desc_t;

  // pin level per slice for one data bit
  function automatic logic [PatW-1:0] make_pattern(input logic bit_val);
    logic [PatW-1:0] one_pat;
    one_pat = (SLICES_PER_BIT == 3) ? PatOne3 : PatOne4;
    return bit_val ? one_pat : PatZero;
  endfunction

endpackage

// ===== rtl/core/albs_front.sv =====
// ----------------------------------------------------------------------------
// Addressable LED bit slicer front end
// Holds configuration, slot and frame counters; classifies each colour item.
// ----------------------------------------------------------------------------
module albs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [albs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [albs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         push_i,
  input  logic [albs_pkg::ColorW-1:0]  color_i,
  input  logic                         q_full_i,
  output logic                         full_o,
  output logic                         q_wr_o,
  output albs_pkg::slot_desc_t         q_wdata_o
);
  import albs_pkg::*;

  logic [LedW-1:0]   led_count_q;
  logic [LatchW-1:0] latch_slots_q;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic              accept;
  logic              latch;
  logic [SlotW:0]    slot_inc;
  logic [SlotW:0]    slot_end;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q   <= LedCountRst;
      latch_slots_q <= LatchSlotsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLedCount:   led_count_q   <= cfg_wdata_i[LedW-1:0];
        RegLatchSlots: latch_slots_q <= cfg_wdata_i[LatchW-1:0];
        default: ;
      endcase
    end
  end

  // slot classification and counter update
  always_comb begin
    accept   = push_i && !q_full_i;
    latch    = slot_q >= SlotW'(led_count_q);
    slot_inc = (SlotW + 1)'(slot_q) + 1'b1;
    slot_end = (SlotW + 1)'(led_count_q) + (SlotW + 1)'(latch_slots_q);
    frame_d  = frame_q;
    if (latch) begin
      slot_d = (slot_inc >= slot_end) ? '0 : slot_inc[SlotW-1:0];
    end else begin
      slot_d = slot_inc[SlotW-1:0];
      if (slot_q == '0) begin
        frame_d = frame_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      frame_q <= '0;
    end else if (accept) begin
      slot_q  <= slot_d;
      frame_q <= frame_d;
    end
  end

  // descriptor into the queue
  assign full_o                 = q_full_i;
  assign q_wr_o                 = accept;
  assign q_wdata_o.color        = color_i;
  assign q_wdata_o.slot_index   = slot_q;
  assign q_wdata_o.in_latch     = latch;
  assign q_wdata_o.frame_number = frame_d;

endmodule

// ===== rtl/core/albs_queue.sv =====
// ----------------------------------------------------------------------------
// Addressable LED bit slicer slot queue
// Short first-in first-out buffer of slot descriptors between front and back.
// ----------------------------------------------------------------------------
module albs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  albs_pkg::slot_desc_t wdata_i,
  input  logic                 rd_i,
  output logic                 full_o,
  output logic                 valid_o,
  output albs_pkg::slot_desc_t rdata_o
);
  import albs_pkg::*;

  slot_desc_t       mem_q [QueueDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/albs_back.sv =====
// ----------------------------------------------------------------------------
// Addressable LED bit slicer back end
// Shifts a slot's colour out one bit per cycle, while results are popped, into a result output register.
// ----------------------------------------------------------------------------
module albs_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  albs_pkg::slot_desc_t         q_rdata_i,
  output logic                         q_rd_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [albs_pkg::PatW-1:0]    slice_pattern_o,
  output logic                         last_bit_o,
  output logic [albs_pkg::SlotW-1:0]   slot_index_o,
  output logic                         in_latch_o,
  output logic [albs_pkg::FrameW-1:0]  frame_number_o
);
  import albs_pkg::*;

  localparam logic [BitCntW-1:0] LastBit = BitCntW'(BITS_PER_SLOT - 1);

  logic                     busy_q;
  logic [BitCntW-1:0]       cnt_q;
  logic [BITS_PER_SLOT-1:0] shreg_q;
  logic [SlotW-1:0]         cur_slot_q;
  logic                     cur_latch_q;
  logic [FrameW-1:0]        cur_frame_q;
  logic                     out_valid_q;
  logic                     adv, last_adv, load, out_xfer;

  // shift and load control
  assign out_xfer = pop_i && out_valid_q;
  assign adv      = busy_q && (!out_valid_q || pop_i);
  assign last_adv = adv && (cnt_q == LastBit);
  assign load     = q_valid_i && (!busy_q || last_adv);
  assign q_rd_o   = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (adv) begin
      busy_q <= !last_adv;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  // current slot payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      shreg_q     <= BITS_PER_SLOT'(q_rdata_i.color);
      cur_slot_q  <= q_rdata_i.slot_index;
      cur_latch_q <= q_rdata_i.in_latch;
      cur_frame_q <= q_rdata_i.frame_number;
    end else if (adv) begin
      shreg_q <= {shreg_q[BITS_PER_SLOT-2:0], 1'b0};
    end
  end

  // result output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      slice_pattern_o <= cur_latch_q ? PatIdle : make_pattern(shreg_q[BITS_PER_SLOT-1]);
      last_bit_o      <= (cnt_q == LastBit);
      slot_index_o    <= cur_slot_q;
      in_latch_o      <= cur_latch_q;
      frame_number_o  <= cur_frame_q;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

// ===== rtl/core/addressable_led_bit_slicer.sv =====
// ----------------------------------------------------------------------------
// Addressable LED bit slicer
// Turns one colour word per slot into 24 time-slice patterns, LEDs then latch.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  input     | push_i / full_o       | color_i
//  result    | empty_o / pop_i       | slice_pattern_o, last_bit_o,
//            |                       | slot_index_o, in_latch_o, frame_number_o
//  config    | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
//  Each item yields 24 results, one per cycle from the back end shift register
//  when results are popped each cycle, and the next item loads with no gap.
//  A pushed item passes the slot queue, shift register and result register.
//  A two-entry slot queue lets the front take items while the back is busy.
//  Reset loads led_count 64 and latch_slots 4 and clears both counters.
//  A withheld pop stalls the back end first; full_o rises once the queue fills.
// ----------------------------------------------------------------------------
`include "addressable_led_bit_slicer_macros.svh"

module addressable_led_bit_slicer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [albs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [albs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [albs_pkg::ColorW-1:0]   color_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [albs_pkg::PatW-1:0]     slice_pattern_o,
  output logic                          last_bit_o,
  output logic [albs_pkg::SlotW-1:0]    slot_index_o,
  output logic                          in_latch_o,
  output logic [albs_pkg::FrameW-1:0]   frame_number_o
);
  import albs_pkg::*;

  logic       q_wr, q_full, q_valid, q_rd;
  slot_desc_t q_wdata, q_rdata;

  // front: configuration, counters, classification
  albs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .color_i     (color_i),
    .q_full_i    (q_full),
    .full_o      (full_o),
    .q_wr_o      (q_wr),
    .q_wdata_o   (q_wdata)
  );

  // slot queue
  albs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  // back: bit serializer
  albs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_rdata_i       (q_rdata),
    .q_rd_o          (q_rd),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .slice_pattern_o (slice_pattern_o),
    .last_bit_o      (last_bit_o),
    .slot_index_o    (slot_index_o),
    .in_latch_o      (in_latch_o),
    .frame_number_o  (frame_number_o)
  );

  // latch slots drive the pin low for every slice
  `ALBS_ASSERT_ALWAYS(a_latch_low, empty_o || !in_latch_o || slice_pattern_o == PatIdle)
  // a slot keeps producing results until its last bit
  `ALBS_ASSERT_NEXT(a_slot_continues, pop_i && !empty_o && !last_bit_o, !empty_o)
  // results of one slot carry the same slot position and frame
  `ALBS_ASSERT_NEXT(a_slot_stable, pop_i && !empty_o && !last_bit_o, $stable(slot_index_o))
  `ALBS_ASSERT_NEXT(a_frame_stable, pop_i && !empty_o && !last_bit_o, $stable(frame_number_o))

endmodule
